[design/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sorted list engine: opcodes, status
// codes, the per-cell command set and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REM_MIN = 3'd1,
    OP_REM_MAX = 3'd2,
    OP_REM_VAL = 3'd3,
    OP_SEARCH  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DOWN,
    CELL_REMOVE_AT,
    CELL_DROP_TAIL
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic     cmp_en;
    logic     upd_en;
    cell_op_e op;
  } ctrl_t;

endpackage

[design/sle_if.sv]
// ----------------------------------------------------------------------------
// sle_in_if / sle_out_if
// Valid/ready channels for requests into and results out of the engine.
// ----------------------------------------------------------------------------
interface sle_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic signed [31:0]          value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sle_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        found;
  logic signed [31:0]          value_out;
  logic [4:0]                  count;

  modport source (output valid, output status, output found, output value_out,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input value_out,
                  input count, output ready);
endinterface

[design/sle_cell.sv]
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted list. Holds a value and a valid bit, compares its
// value against the request key, and on update keeps its value, takes the
// key, takes the value of its left or right neighbor, or clears its valid bit.
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sle_pkg::ctrl_t                    ctrl_i,
  input  logic signed [sle_pkg::VAL_W-1:0]  key_i,
  input  logic signed [sle_pkg::VAL_W-1:0]  left_val_i,
  input  logic                              left_vld_i,
  input  logic                              left_lt_i,
  input  logic signed [sle_pkg::VAL_W-1:0]  right_val_i,
  input  logic                              right_vld_i,
  output logic signed [sle_pkg::VAL_W-1:0]  val_o,
  output logic                              vld_o,
  output logic                              lt_o,
  output logic                              hit_o
);
  import sle_pkg::*;

  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    vld_q, vld_d;
  logic                    lt_q, eq_q;

  // Compare flags are registered in the compare state, ahead of the update.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      lt_q <= vld_q && (val_q < key_i);
      eq_q <= vld_q && (val_q == key_i);
    end
  end

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.upd_en) begin
      case (ctrl_i.op)
        CELL_INSERT: begin
          // The list is sorted, so the first cell not below the key is
          // the one whose left neighbor is below it.
          if (!lt_q) begin
            if (left_lt_i) begin
              val_d = key_i;
              vld_d = 1'b1;
            end else begin
              val_d = left_val_i;
              vld_d = left_vld_i;
            end
          end
        end
        CELL_SHIFT_DOWN: begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end
        CELL_REMOVE_AT: begin
          if (!lt_q) begin
            val_d = right_val_i;
            vld_d = right_vld_i;
          end
        end
        CELL_DROP_TAIL: begin
          if (vld_q && !right_vld_i) begin
            vld_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign lt_o  = lt_q;
  assign hit_o = eq_q && !lt_q && left_lt_i;

endmodule

[design/sorted_list_engine_core.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Bounded ascending list of signed values built as a row of cells.
// ----------------------------------------------------------------------------
// Each request passes through the idle state, in which it is accepted,
// a compare state, in which every cell compares its entry against the
// request value and registers the result, and an update state, in which
// the whole row shifts or loads in parallel and the result is written to
// the output register. A new request is accepted only back in idle after
// the update, so requests do not overlap; the update waits while the
// output register still holds a result that has not been taken.
// ----------------------------------------------------------------------------
module sorted_list_engine_core #(
  parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sle_in_if.sink       req_i,
  sle_out_if.source    rsp_o
);
  import sle_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e                  state_q, state_d;
  op_e                     op_q;
  logic signed [VAL_W-1:0] key_q;
  logic [CNT_W-1:0]        count_q, count_d;
  ctrl_t                   ctrl;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     cell_vld;
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_hit;
  logic [CAPACITY-1:0]     vld_right;
  logic [CAPACITY-1:0]     tail_sel;
  logic signed [VAL_W-1:0] tail_val;
  logic                    any_hit;

  logic                    rsp_valid_q;
  status_e                 rsp_status_q, res_status;
  logic                    rsp_found_q, res_found;
  logic signed [VAL_W-1:0] rsp_value_q, res_value;
  logic [COUNT_W-1:0]      rsp_count_q;
  logic                    load;
  logic                    empty, full;

  // Row of cells.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VAL_W-1:0] left_val, right_val;
    logic                    left_vld, left_lt, right_vld;
    if (k == 0) begin : g_first
      assign left_val = '0;
      assign left_vld = 1'b0;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_val = cell_val[k-1];
      assign left_vld = cell_vld[k-1];
      assign left_lt  = cell_lt[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_inner
      assign right_val = cell_val[k+1];
      assign right_vld = cell_vld[k+1];
    end
    sle_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .key_i      (key_q),
      .left_val_i (left_val),
      .left_vld_i (left_vld),
      .left_lt_i  (left_lt),
      .right_val_i(right_val),
      .right_vld_i(right_vld),
      .val_o      (cell_val[k]),
      .vld_o      (cell_vld[k]),
      .lt_o       (cell_lt[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // The largest entry sits in the last valid cell.
  assign vld_right = {1'b0, cell_vld[CAPACITY-1:1]};
  assign tail_sel  = cell_vld & ~vld_right;
  assign any_hit   = |cell_hit;

  always_comb begin
    tail_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      tail_val = tail_val | (cell_val[k] & {VAL_W{tail_sel[k]}});
    end
  end

  assign empty = (count_q == '0);
  assign full  = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    state_d     = state_q;
    ctrl.cmp_en = 1'b0;
    ctrl.upd_en = 1'b0;
    ctrl.op     = CELL_HOLD;
    load        = 1'b0;
    count_d     = count_q;
    res_status  = ST_OK;
    res_found   = 1'b0;
    res_value   = '0;
    req_i.ready = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = S_COMPARE;
        end
      end
      S_COMPARE: begin
        ctrl.cmp_en = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load        = 1'b1;
          ctrl.upd_en = 1'b1;
          state_d     = S_IDLE;
          case (op_q)
            OP_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_REM_MIN: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.op   = CELL_SHIFT_DOWN;
                res_found = 1'b1;
                res_value = cell_val[0];
                count_d   = count_q - CNT_W'(1);
              end
            end
            OP_REM_MAX: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.op   = CELL_DROP_TAIL;
                res_found = 1'b1;
                res_value = tail_val;
                count_d   = count_q - CNT_W'(1);
              end
            end
            OP_REM_VAL, OP_SEARCH: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (!any_hit) begin
                res_status = ST_NOTFOUND;
              end else begin
                res_found = 1'b1;
                res_value = key_q;
                if (op_q == OP_REM_VAL) begin
                  ctrl.op = CELL_REMOVE_AT;
                  count_d = count_q - CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= op_e'(req_i.opcode);
      key_q <= req_i.value;
    end
    if (load) begin
      rsp_status_q <= res_status;
      rsp_found_q  <= res_found;
      rsp_value_q  <= res_value;
      rsp_count_q  <= COUNT_W'(count_d);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.found     = rsp_found_q;
  assign rsp_o.value_out = rsp_value_q;
  assign rsp_o.count     = rsp_count_q;

  // The number of occupied cells always matches the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == count_q)
    else $error("occupied cells disagree with entry count");

  // Occupied cells form at most one contiguous run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tail_sel))
    else $error("occupied cells are not contiguous");

  // At most one cell can be the first match of the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |-> $onehot0(cell_hit))
    else $error("more than one first-match cell");

  // A result appears only out of the update cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_UPDATE)
    else $error("result produced outside the update cycle");

endmodule
